// ===== rtl/vmt_pkg.sv =====
// vmt_pkg: word types and fixed constants of the 4x4 vector-matrix transform
package vmt_pkg;

  // matrix dimension and storage
  localparam int DIM     = 4;
  localparam int ENTRIES = DIM * DIM;
  localparam int WORD_W  = 32;
  localparam int INDEX_W = 4;

  // operation codes
  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_TRANSFORM = 1'b1;

  // command word
  typedef struct packed {
    logic                      operation;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [WORD_W-1:0]  entry_value;
    logic signed [WORD_W-1:0]  in_x;
    logic signed [WORD_W-1:0]  in_y;
    logic signed [WORD_W-1:0]  in_z;
    logic signed [WORD_W-1:0]  in_w;
  } cmd_t;

  // result word
  typedef struct packed {
    logic signed [WORD_W-1:0]  out_x;
    logic signed [WORD_W-1:0]  out_y;
    logic signed [WORD_W-1:0]  out_z;
    logic signed [WORD_W-1:0]  out_w;
  } res_t;

endpackage

// ===== rtl/vector_matrix_transform_core.sv =====
// vector_matrix_transform_core: pipelined 4x4 homogeneous transform unit
//
// Holds a 4x4 matrix of signed fixed-point words (FRAC_BITS fraction bits) that
// comes out of reset as the identity. A command word with operation load writes
// entry_value into entry entry_index (row times four plus column) and gives no
// result. A command word with operation transform multiplies the row vector
// (in_x, in_y, in_z, in_w) by the stored matrix: each product is rounded toward
// minus infinity by FRAC_BITS bits, the four products of a column are summed at
// full width, and the sum saturates to 32 bits. One command word is taken every
// cycle while cmd_stall is low, loads and transforms freely mixed; a transform
// sees every load taken before it. A transform result passes the product stage
// and the pair-sum stage on its way to the output register. There are three
// register stages (product stage, pair-sum stage, final sum and saturation in
// the output register): the sixteen parallel 32x32 multipliers fill the first
// and the two adder levels the other two. Stall on the result side backs up
// through the pipeline and reaches cmd_stall only when every stage holds a word.
module vector_matrix_transform_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  // command channel
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  vmt_pkg::cmd_t cmd_word,
  // result channel
  output logic          res_valid,
  input  logic          res_stall,
  output vmt_pkg::res_t res_word
);

  localparam int DIM    = vmt_pkg::DIM;
  localparam int WORD_W = vmt_pkg::WORD_W;
  localparam int PROD_W = 2 * WORD_W;
  // width of a product after the floor shift
  localparam int SH_W   = PROD_W - FRAC_BITS;
  // pair sum and full column sum widths
  localparam int PAIR_W = SH_W + 1;
  localparam int SUM_W  = SH_W + 2;
  localparam logic signed [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;
  localparam logic signed [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // handshake and stage flow
  logic cmd_take;
  logic s1_valid;
  logic s2_valid;
  logic s1_ready;
  logic s2_ready;
  logic res_ready;

  // matrix storage, every entry read at its own fixed place
  logic signed [WORD_W-1:0] matrix [vmt_pkg::ENTRIES];

  // stage 1: floor-shifted products, [row][column]
  logic signed [SH_W-1:0]   s1_prod [DIM][DIM];
  logic signed [SH_W-1:0]   prod_next [DIM][DIM];
  logic signed [PROD_W-1:0] prod_full [DIM][DIM];
  logic signed [WORD_W-1:0] vec [DIM];

  // stage 2: pair sums per column
  logic signed [PAIR_W-1:0] s2_lo [DIM];
  logic signed [PAIR_W-1:0] s2_hi [DIM];

  // stage 3: column sums and saturation
  logic signed [SUM_W-1:0]  col_sum [DIM];
  logic signed [WORD_W-1:0] col_sat [DIM];

  // a stage moves when it is empty or the next stage moves
  assign res_ready = !res_valid || !res_stall;
  assign s2_ready  = !s2_valid || res_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign cmd_stall = !s1_ready;
  assign cmd_take  = cmd_valid && s1_ready;

  // matrix: identity after reset, one entry written per load word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          matrix[r*DIM + c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (cmd_take && cmd_word.operation == vmt_pkg::OP_LOAD) begin
      matrix[cmd_word.entry_index] <= cmd_word.entry_value;
    end
  end

  // products straight off the command word, against the current matrix
  always_comb begin
    vec[0] = cmd_word.in_x;
    vec[1] = cmd_word.in_y;
    vec[2] = cmd_word.in_z;
    vec[3] = cmd_word.in_w;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        prod_full[r][c] = PROD_W'(vec[r]) * PROD_W'(matrix[r*DIM + c]);
        // arithmetic shift gives floor rounding
        prod_next[r][c] = SH_W'(prod_full[r][c] >>> FRAC_BITS);
      end
    end
  end

  // column sums and 32-bit saturation
  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      col_sum[c] = SUM_W'(s2_lo[c]) + SUM_W'(s2_hi[c]);
      if (col_sum[c][SUM_W-1:WORD_W-1] == '0 || col_sum[c][SUM_W-1:WORD_W-1] == '1) begin
        col_sat[c] = col_sum[c][WORD_W-1:0];
      end else if (col_sum[c][SUM_W-1]) begin
        col_sat[c] = SAT_MIN;
      end else begin
        col_sat[c] = SAT_MAX;
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= cmd_valid && cmd_word.operation == vmt_pkg::OP_TRANSFORM;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (res_ready) begin
        res_valid <= s2_valid;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s1_prod <= prod_next;
    end
    if (s2_ready && s1_valid) begin
      for (int c = 0; c < DIM; c++) begin
        s2_lo[c] <= PAIR_W'(s1_prod[0][c]) + PAIR_W'(s1_prod[1][c]);
        s2_hi[c] <= PAIR_W'(s1_prod[2][c]) + PAIR_W'(s1_prod[3][c]);
      end
    end
    if (res_ready && s2_valid) begin
      res_word.out_x <= col_sat[0];
      res_word.out_y <= col_sat[1];
      res_word.out_z <= col_sat[2];
      res_word.out_w <= col_sat[3];
    end
  end

`ifndef SYNTHESIS
  // a load word never enters the product stage
  assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd_word.operation == vmt_pkg::OP_LOAD) |=> !s1_valid)
    else $error("load word entered the product stage");

  // an accepted load lands in its matrix entry
  assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd_word.operation == vmt_pkg::OP_LOAD)
      |=> matrix[$past(cmd_word.entry_index)] == $past(cmd_word.entry_value))
    else $error("matrix entry not written by load");

  // backpressure reaches the command side only with every stage full
  assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (s1_valid && s2_valid && res_valid && res_stall))
    else $error("command stalled with room in the pipeline");
`endif

endmodule

// ===== test/vector_matrix_transform_core_test.sv =====
`timescale 1ns / 1ps
// vector_matrix_transform_core_test: self-checking testbench of the 4x4 transform unit
module vector_matrix_transform_core_test;

  localparam int FRAC_BITS = 16;
  localparam logic signed [vmt_pkg::WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [vmt_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [vmt_pkg::WORD_W-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam int PHASE_WORDS = 320;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  vmt_pkg::cmd_t cmd_word = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  vmt_pkg::res_t res_word;

  // local copy of the stored matrix, kept in step with accepted load words
  logic signed [vmt_pkg::WORD_W-1:0] matrix_copy [vmt_pkg::ENTRIES];
  // transformed vectors still owed by the block, oldest first
  vmt_pkg::res_t expected_vectors[$];
  int error_count = 0;
  // idling odds, in percent of cycles
  int send_idle_pct = 0;
  int res_stall_pct = 0;

  vector_matrix_transform_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_word (cmd_word),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_word (res_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    error_count++;
  endtask

  // row vector times the copied matrix: floor-shifted products, wide sum, saturation
  function automatic vmt_pkg::res_t predict_transform(input vmt_pkg::cmd_t w);
    longint vec [vmt_pkg::DIM];
    longint acc;
    logic signed [vmt_pkg::WORD_W-1:0] col_out [vmt_pkg::DIM];
    vmt_pkg::res_t r;
    vec[0] = longint'($signed(w.in_x));
    vec[1] = longint'($signed(w.in_y));
    vec[2] = longint'($signed(w.in_z));
    vec[3] = longint'($signed(w.in_w));
    for (int j = 0; j < vmt_pkg::DIM; j++) begin
      acc = 0;
      for (int i = 0; i < vmt_pkg::DIM; i++) begin
        // arithmetic shift of the exact product rounds toward minus infinity
        acc += (vec[i] * longint'(matrix_copy[i*vmt_pkg::DIM+j])) >>> FRAC_BITS;
      end
      if (acc > longint'(WORD_MAX)) col_out[j] = WORD_MAX;
      else if (acc < longint'(WORD_MIN)) col_out[j] = WORD_MIN;
      else col_out[j] = acc[vmt_pkg::WORD_W-1:0];
    end
    r.out_x = col_out[0];
    r.out_y = col_out[1];
    r.out_z = col_out[2];
    r.out_w = col_out[3];
    return r;
  endfunction

  // word values: mostly modest fixed-point numbers, some extremes, some raw noise
  function automatic logic signed [vmt_pkg::WORD_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    if (sel < 65) return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
    if (sel < 80) begin
      case ($urandom_range(5))
        0: return WORD_MAX;
        1: return WORD_MIN;
        2: return '0;
        3: return -32'sd1;
        4: return 32'sd1;
        default: return ONE_Q;
      endcase
    end
    return $urandom();
  endfunction

  // the fields that an operation ignores are filled with noise
  function automatic vmt_pkg::cmd_t make_load(input int idx,
                                              input logic signed [vmt_pkg::WORD_W-1:0] value);
    vmt_pkg::cmd_t w;
    w.operation   = vmt_pkg::OP_LOAD;
    w.entry_index = idx[vmt_pkg::INDEX_W-1:0];
    w.entry_value = value;
    w.in_x = $urandom();
    w.in_y = $urandom();
    w.in_z = $urandom();
    w.in_w = $urandom();
    return w;
  endfunction

  function automatic vmt_pkg::cmd_t make_transform(
      input logic signed [vmt_pkg::WORD_W-1:0] x,
      input logic signed [vmt_pkg::WORD_W-1:0] y,
      input logic signed [vmt_pkg::WORD_W-1:0] z,
      input logic signed [vmt_pkg::WORD_W-1:0] wc);
    vmt_pkg::cmd_t w;
    int idx;
    idx = $urandom_range(vmt_pkg::ENTRIES - 1);
    w.operation   = vmt_pkg::OP_TRANSFORM;
    w.entry_index = idx[vmt_pkg::INDEX_W-1:0];
    w.entry_value = $urandom();
    w.in_x = x;
    w.in_y = y;
    w.in_z = z;
    w.in_w = wc;
    return w;
  endfunction

  // drive one command word, called at a rising edge; returns at the edge that takes it
  task automatic send_word(input vmt_pkg::cmd_t w);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= w;
    do @(posedge clk); while (cmd_stall);
    // accepted here: update the matrix copy or queue the expected vector
    if (w.operation == vmt_pkg::OP_LOAD) matrix_copy[w.entry_index] = w.entry_value;
    else expected_vectors.push_back(predict_transform(w));
  endtask

  // drop valid and hold off until every owed vector has come back
  task automatic wait_drain();
    cmd_valid <= 1'b0;
    while (expected_vectors.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic compare_field(input string name,
                               input logic signed [vmt_pkg::WORD_W-1:0] got,
                               input logic signed [vmt_pkg::WORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // result side: random stall, and each taken word checked against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid === 1'b1 && !res_stall) begin
        if (expected_vectors.size() == 0) begin
          report_mismatch("result word with no transform outstanding");
        end else begin
          vmt_pkg::res_t want;
          want = expected_vectors.pop_front();
          compare_field("out_x", res_word.out_x, want.out_x);
          compare_field("out_y", res_word.out_y, want.out_y);
          compare_field("out_z", res_word.out_z, want.out_z);
          compare_field("out_w", res_word.out_w, want.out_w);
        end
      end
      res_stall <= res_stall_pct != 0 && $urandom_range(99) < res_stall_pct;
    end
  end

  // identity after reset passes every component through unchanged
  task automatic test_identity_at_reset();
    send_word(make_transform(WORD_MAX, WORD_MIN, '0, -32'sd1));
    send_word(make_transform(32'sd1, -ONE_Q, ONE_Q, WORD_MIN));
  endtask

  // extreme entries on the diagonal, then vectors that overflow and round
  task automatic test_rounding_and_saturation();
    send_word(make_load(0, WORD_MAX));
    send_word(make_load(5, WORD_MIN));
    send_word(make_load(10, -32'sd1));
    send_word(make_load(15, 32'sd1));
    // positive and negative saturation, plus truncated small products
    send_word(make_transform(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    send_word(make_transform(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    // tiny negative products must floor to minus one, not zero
    send_word(make_transform(-32'sd1, -32'sd1, -32'sd1, -32'sd1));
    send_word(make_transform(32'sd1, -32'sd1, 32'sd1, -32'sd1));
  endtask

  // a load right before a transform must already be visible to it
  task automatic test_load_visibility();
    send_word(make_load(3, 32'sd2 <<< FRAC_BITS));
    send_word(make_transform(ONE_Q, ONE_Q, ONE_Q, ONE_Q));
    send_word(make_load(12, WORD_MIN));
    send_word(make_load(3, ONE_Q));
    send_word(make_transform(32'sd3 <<< FRAC_BITS, -ONE_Q, ONE_Q, ONE_Q));
    wait_drain();
  endtask

  // mixed load and transform traffic at the given idling odds
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    res_stall_pct = stall_pct;
    for (int n = 0; n < PHASE_WORDS; n++) begin
      if ($urandom_range(99) < 30)
        send_word(make_load($urandom_range(vmt_pkg::ENTRIES - 1), pick_value()));
      else
        send_word(make_transform(pick_value(), pick_value(), pick_value(), pick_value()));
    end
    wait_drain();
  endtask

  initial begin
    for (int i = 0; i < vmt_pkg::ENTRIES; i++)
      matrix_copy[i] = (i / vmt_pkg::DIM == i % vmt_pkg::DIM) ? ONE_Q : '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity_at_reset();
    test_rounding_and_saturation();
    test_load_visibility();
    test_random_traffic(0, 0);
    test_random_traffic(47, 0);
    test_random_traffic(0, 47);
    test_random_traffic(37, 37);

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
